// ----- hw/rtl/perspective_divide_viewport_macros.svh -----
// Assertion helpers used by the RTL of the perspective divide block.
// Both need clk_i, PDV_ASSERT also rst_ni, in the module that uses them.
`ifndef PERSPECTIVE_DIVIDE_VIEWPORT_MACROS_SVH
`define PERSPECTIVE_DIVIDE_VIEWPORT_MACROS_SVH

// Checked on every rising edge while the block is out of reset.
`define PDV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define PDV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- hw/rtl/pdv_pkg.sv -----
package pdv_pkg;

  localparam int unsigned CanvasW   = 13;
  localparam int unsigned DenW      = 44;
  localparam int unsigned NdcLimLog = 40;
  localparam int unsigned NumLanes  = 4;

  localparam logic [CanvasW-1:0] CanvasWReset = 13'd640;
  localparam logic [CanvasW-1:0] CanvasHReset = 13'd480;

  localparam logic [1:0] LaneX = 2'd0;
  localparam logic [1:0] LaneY = 2'd1;
  localparam logic [1:0] LaneZ = 2'd2;
  localparam logic [1:0] LaneR = 2'd3;

  typedef enum logic {
    REG_CANVAS_W = 1'b0,
    REG_CANVAS_H = 1'b1
  } reg_idx_e;

  // Per-vertex control that rides along with the quotient lanes.
  typedef struct packed {
    logic                mode;
    logic                w_zero;
    logic                outside;
    logic [NumLanes-1:0] neg;
  } side_t;

  typedef struct packed {
    logic saturated;
    logic w_zero;
    logic outside;
  } out_flags_t;

  // Magnitude width of the inverse-mode numerator 2x - W*one.
  function automatic int unsigned inv_mag_w(input int unsigned f);
    return (f + 14 > 33) ? f + 14 : 33;
  endfunction

  // Width of every dividend lane, and so the number of divider cells.
  function automatic int unsigned quot_w(input int unsigned f);
    return inv_mag_w(f) + f + 1;
  endfunction

endpackage

// ----- hw/rtl/pdv_div_cell.sv -----
module pdv_div_cell #(
  parameter int unsigned NumW = 50
) (
  input  logic                                                 clk_i,
  input  logic                                                 rst_ni,
  input  logic                                                 valid_i,
  output logic                                                 ready_o,
  input  logic [pdv_pkg::NumLanes-1:0][NumW-1:0]               num_i,
  input  logic [pdv_pkg::NumLanes-1:0][pdv_pkg::DenW-1:0]      den_i,
  input  logic [pdv_pkg::NumLanes-1:0][pdv_pkg::DenW-1:0]      rem_i,
  input  pdv_pkg::side_t                                       side_i,
  output logic                                                 valid_o,
  input  logic                                                 ready_i,
  output logic [pdv_pkg::NumLanes-1:0][NumW-1:0]               num_o,
  output logic [pdv_pkg::NumLanes-1:0][pdv_pkg::DenW-1:0]      den_o,
  output logic [pdv_pkg::NumLanes-1:0][pdv_pkg::DenW-1:0]      rem_o,
  output pdv_pkg::side_t                                       side_o
);
  import pdv_pkg::*;

  logic                              valid_q;
  logic [NumLanes-1:0][NumW-1:0]     num_d, num_q;
  logic [NumLanes-1:0][DenW-1:0]     rem_d, rem_q, den_q;
  logic [NumLanes-1:0][DenW:0]       shf, dif;
  logic [NumLanes-1:0]               ge;
  side_t                             side_q;

  // One restoring step per lane: the dividend shifts out at the top while
  // the quotient bit enters at the bottom.
  always_comb begin
    for (int l = 0; l < NumLanes; l++) begin
      shf[l]   = {rem_i[l], num_i[l][NumW-1]};
      dif[l]   = shf[l] - {1'b0, den_i[l]};
      ge[l]    = shf[l] >= {1'b0, den_i[l]};
      rem_d[l] = ge[l] ? dif[l][DenW-1:0] : shf[l][DenW-1:0];
      num_d[l] = {num_i[l][NumW-2:0], ge[l]};
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      num_q  <= num_d;
      rem_q  <= rem_d;
      den_q  <= den_i;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign num_o   = num_q;
  assign rem_o   = rem_q;
  assign den_o   = den_q;
  assign side_o  = side_q;

endmodule

// ----- hw/rtl/pdv_prep.sv -----
module pdv_prep #(
  parameter int unsigned FracBits = 16,
  parameter int unsigned NumW     = 50
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            valid_i,
  output logic                                            ready_o,
  input  logic                                            mode_i,
  input  logic signed [31:0]                              x_i,
  input  logic signed [31:0]                              y_i,
  input  logic signed [31:0]                              z_i,
  input  logic signed [31:0]                              w_i,
  input  logic [pdv_pkg::CanvasW-1:0]                     cw_i,
  input  logic [pdv_pkg::CanvasW-1:0]                     ch_i,
  output logic                                            valid_o,
  input  logic                                            ready_i,
  output logic [pdv_pkg::NumLanes-1:0][NumW-1:0]          num_o,
  output logic [pdv_pkg::NumLanes-1:0][pdv_pkg::DenW-1:0] den_o,
  output pdv_pkg::side_t                                  side_o
);
  import pdv_pkg::*;

  localparam int unsigned IMagW = inv_mag_w(FracBits);
  localparam int unsigned IW    = IMagW + 1;
  localparam int unsigned MulW  = CanvasW + 32;

  logic signed [32:0]   xe, ye, ze, we, nwe;
  logic signed [IW-1:0] cw_fix, ch_fix, ix_s, iy_s, ix_m, iy_m;
  logic [31:0]          ax_d, ay_d, az_d, aw_d;
  logic [MulW-1:0]      dxw_d, dyw_d;
  side_t                side_d;

  logic                 valid_q;
  logic [31:0]          ax_q, ay_q, az_q, aw_q;
  logic [IMagW-1:0]     imx_q, imy_q;
  logic [DenW-1:0]      dxw_q, dyw_q;
  side_t                side_q;

  always_comb begin
    xe  = 33'(x_i);
    ye  = 33'(y_i);
    ze  = 33'(z_i);
    we  = 33'(w_i);
    nwe = -we;

    ax_d = x_i[31] ? 32'(-x_i) : 32'(x_i);
    ay_d = y_i[31] ? 32'(-y_i) : 32'(y_i);
    az_d = z_i[31] ? 32'(-z_i) : 32'(z_i);
    aw_d = w_i[31] ? 32'(-w_i) : 32'(w_i);

    // Inverse numerators 2x - W*one and H*one - 2y.
    cw_fix = $signed(IW'(cw_i) << FracBits);
    ch_fix = $signed(IW'(ch_i) << FracBits);
    ix_s   = (IW'(x_i) <<< 1) - cw_fix;
    iy_s   = ch_fix - (IW'(y_i) <<< 1);
    ix_m   = ix_s[IW-1] ? -ix_s : ix_s;
    iy_m   = iy_s[IW-1] ? -iy_s : iy_s;

    dxw_d = cw_i * aw_d;
    dyw_d = ch_i * aw_d;

    side_d.mode    = mode_i;
    side_d.w_zero  = (w_i == 32'sd0);
    side_d.outside = !((xe <= we) && (xe >= nwe) && (ye <= we) && (ye >= nwe) &&
                       (ze <= we) && !z_i[31]);
    side_d.neg[LaneX] = (mode_i ? ix_s[IW-1] : x_i[31]) ^ w_i[31];
    side_d.neg[LaneY] = (mode_i ? iy_s[IW-1] : y_i[31]) ^ w_i[31];
    side_d.neg[LaneZ] = z_i[31] ^ w_i[31];
    side_d.neg[LaneR] = w_i[31];
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      ax_q   <= ax_d;
      ay_q   <= ay_d;
      az_q   <= az_d;
      aw_q   <= aw_d;
      imx_q  <= ix_m[IMagW-1:0];
      imy_q  <= iy_m[IMagW-1:0];
      dxw_q  <= dxw_d[DenW-1:0];
      dyw_q  <= dyw_d[DenW-1:0];
      side_q <= side_d;
    end
  end

  // Each dividend carries half the divisor so that the floor quotient
  // rounds to nearest with ties away from zero.
  always_comb begin
    den_o[LaneZ] = DenW'(aw_q);
    den_o[LaneR] = DenW'(aw_q);
    num_o[LaneZ] = (NumW'(az_q) << FracBits) + NumW'(aw_q >> 1);
    num_o[LaneR] = (NumW'(1) << (2 * FracBits)) + NumW'(aw_q >> 1);
    if (side_q.mode) begin
      den_o[LaneX] = dxw_q;
      den_o[LaneY] = dyw_q;
      num_o[LaneX] = (NumW'(imx_q) << FracBits) + NumW'(dxw_q >> 1);
      num_o[LaneY] = (NumW'(imy_q) << FracBits) + NumW'(dyw_q >> 1);
    end else begin
      den_o[LaneX] = DenW'(aw_q);
      den_o[LaneY] = DenW'(aw_q);
      num_o[LaneX] = (NumW'(ax_q) << FracBits) + NumW'(aw_q >> 1);
      num_o[LaneY] = (NumW'(ay_q) << FracBits) + NumW'(aw_q >> 1);
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;

endmodule

// ----- hw/rtl/pdv_post.sv -----
module pdv_post #(
  parameter int unsigned FracBits = 16,
  parameter int unsigned NumW     = 50
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  output logic                                   ready_o,
  input  logic [pdv_pkg::NumLanes-1:0][NumW-1:0] quot_i,
  input  pdv_pkg::side_t                         side_i,
  input  logic [pdv_pkg::CanvasW-1:0]            cw_i,
  input  logic [pdv_pkg::CanvasW-1:0]            ch_i,
  output logic                                   valid_o,
  input  logic                                   ready_i,
  output logic [31:0]                            out_x_o,
  output logic [31:0]                            out_y_o,
  output logic [31:0]                            out_z_o,
  output logic [31:0]                            out_rhw_o,
  output pdv_pkg::out_flags_t                    flags_o
);
  import pdv_pkg::*;

  localparam int unsigned NdcW  = NdcLimLog + 2;
  localparam int unsigned SumW  = NdcW + 1;
  localparam int unsigned ProdW = SumW + CanvasW + 1;
  localparam logic [NumW-1:0] NdcLim = NumW'(1) << NdcLimLog;
  localparam logic [NumW-1:0] NegMax = NumW'(1) << 31;
  localparam logic [NumW-1:0] PosMax = (NumW'(1) << 31) - NumW'(1);

  function automatic logic [32:0] sat_quot(input logic neg, input logic [NumW-1:0] q);
    logic [31:0] lo;
    logic        over;
    lo   = q[31:0];
    over = neg ? (q > NegMax) : (q > PosMax);
    if (over) begin
      return {1'b1, neg ? 32'h8000_0000 : 32'h7fff_ffff};
    end
    return {1'b0, neg ? (~lo + 32'd1) : lo};
  endfunction

  // Halve with ties away from zero, then clamp to the 32-bit range.
  function automatic logic [32:0] sat_half(input logic signed [ProdW-1:0] p);
    logic signed [ProdW-1:0] h;
    logic [ProdW-32:0]       top;
    h   = p[ProdW-1] ? (p >>> 1) : ((p + ProdW'(1)) >>> 1);
    top = h[ProdW-1:31];
    if (&top || ~|top) begin
      return {1'b0, h[31:0]};
    end
    return {1'b1, h[ProdW-1] ? 32'h8000_0000 : 32'h7fff_ffff};
  endfunction

  logic [NdcLimLog:0]       magx, magy;
  logic signed [NdcW-1:0]   mxe, mye, nx, ny;
  logic signed [SumW-1:0]   one_s, sx, sy;
  logic signed [ProdW-1:0]  px_d, py_d;

  logic                          s1_valid_q;
  logic signed [ProdW-1:0]       px_q, py_q;
  logic [NumLanes-1:0][NumW-1:0] quot_q;
  side_t                         side_q;
  logic                          s1_ready;
  logic                          out_ready;

  logic [32:0] rx, ry, rz, rr;
  logic        out_valid_q;
  logic [31:0] ox_q, oy_q, oz_q, or_q;
  out_flags_t  flags_d, flags_q;

  // Forward viewport products (1 +- x/w) * size, with x/w held to +-2^40.
  always_comb begin
    magx  = (quot_i[LaneX] > NdcLim) ? NdcLim[NdcLimLog:0] : quot_i[LaneX][NdcLimLog:0];
    magy  = (quot_i[LaneY] > NdcLim) ? NdcLim[NdcLimLog:0] : quot_i[LaneY][NdcLimLog:0];
    mxe   = $signed({1'b0, magx});
    mye   = $signed({1'b0, magy});
    nx    = side_i.neg[LaneX] ? -mxe : mxe;
    ny    = side_i.neg[LaneY] ? -mye : mye;
    one_s = $signed(SumW'(1) << FracBits);
    sx    = one_s + SumW'(nx);
    sy    = one_s - SumW'(ny);
    px_d  = ProdW'(sx) * ProdW'($signed({1'b0, cw_i}));
    py_d  = ProdW'(sy) * ProdW'($signed({1'b0, ch_i}));
  end

  assign out_ready = !out_valid_q || ready_i;
  assign s1_ready  = !s1_valid_q || out_ready;
  assign ready_o   = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= valid_i;
      end
      if (out_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && s1_ready) begin
      px_q   <= px_d;
      py_q   <= py_d;
      quot_q <= quot_i;
      side_q <= side_i;
    end
  end

  always_comb begin
    if (side_q.mode) begin
      rx = sat_quot(side_q.neg[LaneX], quot_q[LaneX]);
      ry = sat_quot(side_q.neg[LaneY], quot_q[LaneY]);
    end else begin
      rx = sat_half(px_q);
      ry = sat_half(py_q);
    end
    rz = sat_quot(side_q.neg[LaneZ], quot_q[LaneZ]);
    rr = sat_quot(side_q.neg[LaneR], quot_q[LaneR]);
    flags_d.w_zero    = side_q.w_zero;
    flags_d.outside   = side_q.outside && !side_q.w_zero;
    flags_d.saturated = (rx[32] | ry[32] | rz[32] | rr[32]) && !side_q.w_zero;
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && out_ready) begin
      ox_q    <= side_q.w_zero ? 32'd0 : rx[31:0];
      oy_q    <= side_q.w_zero ? 32'd0 : ry[31:0];
      oz_q    <= side_q.w_zero ? 32'd0 : rz[31:0];
      or_q    <= side_q.w_zero ? 32'd0 : rr[31:0];
      flags_q <= flags_d;
    end
  end

  assign valid_o   = out_valid_q;
  assign out_x_o   = ox_q;
  assign out_y_o   = oy_q;
  assign out_z_o   = oz_q;
  assign out_rhw_o = or_q;
  assign flags_o   = flags_q;

endmodule

// ----- hw/rtl/perspective_divide_viewport.sv -----
// Channel   Direction  Handshake              Payload
// s_axis    in         tvalid / tready        tdata x,y,z,w; tuser mode
// m_axis    out        tvalid / tready        tdata x,y,z,rhw; tuser flags
// cfg       in         cfg_we_i (no wait)     cfg_idx_i, cfg_wdata_i
//
// One vertex per cycle is accepted and delivered in steady flow.
// A vertex passes the prep register, Q divider cells of one quotient bit each and the
// post registers; Q = max(33, FRAC_BITS + 14) + FRAC_BITS + 1 (50 at FRAC_BITS = 16).
// Each stage passes ready upstream, so a stalled output only holds the input
// once every stage in the chain is full.
// Reset clears all valid flags and loads a 640 by 480 canvas.
module perspective_divide_viewport #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [127:0]                  s_axis_tdata,   // in_x, in_y, in_z, in_w
  input  logic                          s_axis_tuser,   // mode
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [127:0]                  m_axis_tdata,   // out_x, out_y, out_z, out_rhw
  output logic [2:0]                    m_axis_tuser,   // outside_clip, w_zero, saturated
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [pdv_pkg::CanvasW-1:0]   cfg_wdata_i
);
  import pdv_pkg::*;

  localparam int unsigned NumW = quot_w(FRAC_BITS);

  logic [CanvasW-1:0] canvas_w_q, canvas_h_q, cw_eff, ch_eff;

  logic [NumW:0]                           c_valid, c_ready;
  logic [NumW:0][NumLanes-1:0][NumW-1:0]   c_num;
  logic [NumW:0][NumLanes-1:0][DenW-1:0]   c_den, c_rem;
  side_t                                   c_side [NumW+1];
  out_flags_t                              flags;
  reg_idx_e                                cfg_idx;

  assign cfg_idx = reg_idx_e'(cfg_idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      canvas_w_q <= CanvasWReset;
      canvas_h_q <= CanvasHReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx)
        REG_CANVAS_W: canvas_w_q <= cfg_wdata_i;
        REG_CANVAS_H: canvas_h_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // A zero canvas dimension behaves as one pixel.
  assign cw_eff = (canvas_w_q == '0) ? CanvasW'(1) : canvas_w_q;
  assign ch_eff = (canvas_h_q == '0) ? CanvasW'(1) : canvas_h_q;

  pdv_prep #(
    .FracBits (FRAC_BITS),
    .NumW     (NumW)
  ) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .mode_i  (s_axis_tuser),
    .x_i     ($signed(s_axis_tdata[31:0])),
    .y_i     ($signed(s_axis_tdata[63:32])),
    .z_i     ($signed(s_axis_tdata[95:64])),
    .w_i     ($signed(s_axis_tdata[127:96])),
    .cw_i    (cw_eff),
    .ch_i    (ch_eff),
    .valid_o (c_valid[0]),
    .ready_i (c_ready[0]),
    .num_o   (c_num[0]),
    .den_o   (c_den[0]),
    .side_o  (c_side[0])
  );

  assign c_rem[0] = '0;

  for (genvar k = 0; k < NumW; k++) begin : g_cell
    pdv_div_cell #(
      .NumW (NumW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (c_valid[k]),
      .ready_o (c_ready[k]),
      .num_i   (c_num[k]),
      .den_i   (c_den[k]),
      .rem_i   (c_rem[k]),
      .side_i  (c_side[k]),
      .valid_o (c_valid[k+1]),
      .ready_i (c_ready[k+1]),
      .num_o   (c_num[k+1]),
      .den_o   (c_den[k+1]),
      .rem_o   (c_rem[k+1]),
      .side_o  (c_side[k+1])
    );
  end

  pdv_post #(
    .FracBits (FRAC_BITS),
    .NumW     (NumW)
  ) u_post (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (c_valid[NumW]),
    .ready_o   (c_ready[NumW]),
    .quot_i    (c_num[NumW]),
    .side_i    (c_side[NumW]),
    .cw_i      (cw_eff),
    .ch_i      (ch_eff),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .out_x_o   (m_axis_tdata[31:0]),
    .out_y_o   (m_axis_tdata[63:32]),
    .out_z_o   (m_axis_tdata[95:64]),
    .out_rhw_o (m_axis_tdata[127:96]),
    .flags_o   (flags)
  );

  assign m_axis_tuser = flags;

`include "perspective_divide_viewport_macros.svh"

  // A zero w delivers a clean all-zero result.
  `PDV_ASSERT(a_wzero_clean, m_axis_tvalid && m_axis_tuser[1] |-> (m_axis_tdata == '0) && !m_axis_tuser[0] && !m_axis_tuser[2], "zero w result is not clean")
  // The input only stalls when every stage is full behind a stalled output.
  `PDV_ASSERT_ALWAYS(a_stall_origin, !s_axis_tready |-> m_axis_tvalid && !m_axis_tready, "input stalled without output backpressure")
  // A width write lands in the register on the next edge.
  `PDV_ASSERT(a_cfg_width, cfg_we_i && (cfg_idx_i == REG_CANVAS_W) |=> canvas_w_q == $past(cfg_wdata_i), "canvas width write lost")

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
  import pdv_pkg::*;

  localparam int unsigned Frac = 16;
  localparam int unsigned LatencyCycles = 60;

  typedef struct packed {
    logic        mode;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] w;
  } vertex_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] rhw;
    logic        outside;
    logic        w_zero;
    logic        saturated;
  } screen_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [127:0]        s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [127:0]        m_axis_tdata;
  logic [2:0]          m_axis_tuser;
  logic                cfg_we_i = 1'b0;
  logic                cfg_idx_i = 1'b0;
  logic [CanvasW-1:0]  cfg_wdata_i = '0;

  perspective_divide_viewport #(.FRAC_BITS(Frac)) DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  always #5 clk_i = ~clk_i;

  vertex_t     pending_vertices[$];
  screen_t     expected_screen[$];
  logic [12:0] canvas_w = CanvasWReset;
  logic [12:0] canvas_h = CanvasHReset;
  int          errors = 0;
  bit          calm = 1'b0;
  int          hold_cycles = 0;
  bit          send_busy = 1'b0;

  function automatic logic signed [127:0] round_div(input logic signed [127:0] n,
                                                    input logic signed [127:0] d);
    logic        neg;
    logic [127:0] un;
    logic [127:0] ud;
    logic [127:0] q;
    neg = (n < 0) != (d < 0);
    un = (n < 0) ? -n : n;
    ud = (d < 0) ? -d : d;
    q = (un + ud / 2) / ud;
    return neg ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout logic flag);
    if (v > 128'sd2147483647) begin
      flag = 1'b1;
      return 32'h7fffffff;
    end
    if (v < -128'sd2147483648) begin
      flag = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [127:0] clamp_ndc(input logic signed [127:0] v);
    logic signed [127:0] lim;
    lim = 128'sd1 <<< NdcLimLog;
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic screen_t project_vertex(input vertex_t v);
    screen_t r;
    logic signed [127:0] x, y, z, w, one, cw, ch, rx, ry, nx, ny;
    logic sat;
    r = '0;
    sat = 1'b0;
    x = $signed(v.x); y = $signed(v.y); z = $signed(v.z); w = $signed(v.w);
    one = 128'sd1 <<< Frac;
    cw = (canvas_w == 0) ? 1 : canvas_w;
    ch = (canvas_h == 0) ? 1 : canvas_h;
    if (w == 0) begin
      r.w_zero = 1'b1;
      return r;
    end
    r.outside = !(x <= w && x >= -w && y <= w && y >= -w && z <= w && z >= 0);
    if (!v.mode) begin
      nx = clamp_ndc(round_div(x * one, w));
      ny = clamp_ndc(round_div(y * one, w));
      rx = round_div((one + nx) * cw, 2);
      ry = round_div((one - ny) * ch, 2);
    end else begin
      rx = round_div((2 * x - cw * one) * one, cw * w);
      ry = round_div((ch * one - 2 * y) * one, ch * w);
    end
    r.x = clamp32(rx, sat);
    r.y = clamp32(ry, sat);
    r.z = clamp32(round_div(z * one, w), sat);
    r.rhw = clamp32(round_div(128'sd1 <<< (2 * Frac), w), sat);
    r.saturated = sat;
    return r;
  endfunction

  // Driver: at the falling edge after acceptance, a new vertex or a gap begins.
  int send_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && !send_busy) begin
        // keep offering the current vertex
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_vertices.size() > 0) begin
        vertex_t v;
        v = pending_vertices.pop_front();
        expected_screen.push_back(project_vertex(v));
        s_axis_tdata <= {v.w, v.z, v.y, v.x};
        s_axis_tuser <= v.mode;
        s_axis_tvalid <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 12);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Tracks acceptance so the driver knows when the offered vertex was taken.
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) send_busy <= 1'b1;
    else send_busy <= 1'b0;
  end

  int recv_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        m_axis_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) recv_gap <= $urandom_range(1, 12);
      end
    end
  end

  // Monitor.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      screen_t got, want;
      got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
             m_axis_tdata[127:96], m_axis_tuser[0], m_axis_tuser[1], m_axis_tuser[2]};
      if (expected_screen.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, got);
      end else begin
        want = expected_screen.pop_front();
        if (got.x !== want.x)
          begin errors++; $display("%0t: out_x exp %h got %h", $time, want.x, got.x); end
        if (got.y !== want.y)
          begin errors++; $display("%0t: out_y exp %h got %h", $time, want.y, got.y); end
        if (got.z !== want.z)
          begin errors++; $display("%0t: out_z exp %h got %h", $time, want.z, got.z); end
        if (got.rhw !== want.rhw)
          begin errors++; $display("%0t: out_rhw exp %h got %h", $time, want.rhw, got.rhw); end
        if (got.outside !== want.outside)
          begin errors++; $display("%0t: outside exp %b got %b", $time, want.outside,
                                   got.outside); end
        if (got.w_zero !== want.w_zero)
          begin errors++; $display("%0t: w_zero exp %b got %b", $time, want.w_zero,
                                   got.w_zero); end
        if (got.saturated !== want.saturated)
          begin errors++; $display("%0t: saturated exp %b got %b", $time, want.saturated,
                                   got.saturated); end
      end
    end
  end

  function automatic logic [31:0] rand_coord(input logic [31:0] w);
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $signed(w) / $signed($urandom_range(1, 4));
      2: return -($signed(w) / $signed($urandom_range(1, 4)));
      3: return $urandom_range(0, 32'h000fffff);
      4: return w;
      default: return $urandom_range(0, 32'h0007ffff) - 32'h00040000;
    endcase
  endfunction

  function automatic vertex_t rand_vertex();
    vertex_t v;
    v.mode = $urandom_range(0, 1);
    case ($urandom_range(0, 9))
      0: v.w = $urandom();
      1: v.w = 32'h0;
      2: v.w = $urandom_range(1, 255);
      default: v.w = $urandom_range(32'h00004000, 32'h00400000);
    endcase
    if ($urandom_range(0, 3) == 0) v.w = -v.w;
    v.x = rand_coord(v.w);
    v.y = rand_coord(v.w);
    v.z = rand_coord(v.w);
    if (v.mode) begin
      v.x = $urandom_range(0, canvas_w) << 16;
      v.y = $urandom_range(0, canvas_h) << 16;
      if ($urandom_range(0, 4) == 0) v.x = $urandom();
    end
    return v;
  endfunction

  task automatic drain_and_write(input reg_idx_e idx, input logic [12:0] val);
    while (pending_vertices.size() > 0 || expected_screen.size() > 0 || s_axis_tvalid)
      @(posedge clk_i);
    repeat (LatencyCycles) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_CANVAS_W) canvas_w = val;
    else canvas_h = val;
  endtask

  task automatic push_vertex(input logic m, input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z, input logic [31:0] w);
    vertex_t v;
    v = {m, x, y, z, w};
    pending_vertices.push_back(v);
  endtask

  logic [12:0] widths[5] = '{13'd1, 13'd4096, 13'd0, 13'd8191, 13'd1920};
  logic [12:0] heights[5] = '{13'd4096, 13'd1, 13'd8191, 13'd0, 13'd1080};

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // Directed corners under the reset canvas.
    push_vertex(0, 0, 0, 0, 32'h00010000);
    push_vertex(1, 0, 0, 0, 32'h00010000);
    push_vertex(0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h00000001);
    push_vertex(1, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h00000001);
    push_vertex(0, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'hffffffff);
    push_vertex(0, 32'h12345678, 32'h9abcdef0, 32'h55555555, 32'h0);
    push_vertex(1, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'h0);
    push_vertex(0, 32'h00010000, 32'hffff0000, 32'h00010000, 32'h00010000);
    push_vertex(0, 32'h00010001, 32'h0, 32'h0, 32'h00010000);
    push_vertex(0, 0, 0, 32'hffffffff, 32'h00010000);
    push_vertex(1, 32'h80000000, 32'h80000000, 0, 32'h80000000);
    push_vertex(0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    push_vertex(0, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    push_vertex(1, 32'h01400000, 32'h00f00000, 32'h00008000, 32'hfffe0000);
    push_vertex(0, 32'h00008000, 32'hffff8000, 32'h00008000, 32'h00030000);
    for (int i = 0; i < 100; i++) pending_vertices.push_back(rand_vertex());
    // Long output hold-off so the pipeline fills and back-pressures the input.
    @(negedge clk_i);
    hold_cycles <= 150;
    for (int p = 0; p < 5; p++) begin
      drain_and_write(REG_CANVAS_W, widths[p]);
      drain_and_write(REG_CANVAS_H, heights[p]);
      for (int i = 0; i < 100; i++) pending_vertices.push_back(rand_vertex());
    end
    drain_and_write(REG_CANVAS_W, CanvasWReset);
    drain_and_write(REG_CANVAS_H, CanvasHReset);
    calm = 1'b1;
    for (int i = 0; i < 120; i++) pending_vertices.push_back(rand_vertex());
    while (pending_vertices.size() > 0 || expected_screen.size() > 0 || s_axis_tvalid)
      @(posedge clk_i);
    repeat (LatencyCycles) @(posedge clk_i);
    if (errors == 0 && expected_screen.size() == 0)
      $display("perspective_divide_viewport: match");
    else
      $display("perspective_divide_viewport: mismatch");
    $finish;
  end

  initial begin
    #2000000;
    $display("perspective_divide_viewport: mismatch");
    $finish;
  end

endmodule

// ----- perspective_divide_viewport.f -----
+incdir+hw/rtl
hw/rtl/pdv_pkg.sv
hw/rtl/pdv_div_cell.sv
hw/rtl/pdv_prep.sv
hw/rtl/pdv_post.sv
hw/rtl/perspective_divide_viewport.sv
tb/sv/testbench.sv
